// File: design/tic_pkg.sv
`timescale 1ns / 1ps
package tic_pkg;

	// Default sizes of the matrix dimension and of the linear index.
	localparam int DIM_BITS_DEF   = 16;
	localparam int INDEX_BITS_DEF = 32;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_ROW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPLIT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd5;

	// Triangle modes.
	localparam logic MODE_UPPER = 1'b0;
	localparam logic MODE_LOWER = 1'b1;

	// Square root unit: 64-bit radicand, two radicand bits per step.
	localparam int RAD_W      = 64;
	localparam int ROOT_W     = 32;
	localparam int SQRT_STEPS = 32;
	localparam int SREM_W     = 35;

	// Control bits that travel alongside each item.
	typedef struct packed {
		logic valid;
		logic inr;
		logic top;
	} tic_ctl_t;

	function automatic int max_int(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

// File: design/tic_front.sv
`timescale 1ns / 1ps
module tic_front import tic_pkg::*; #(
	parameter int DIM_BITS   = DIM_BITS_DEF,
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [INDEX_BITS-1:0] linear_index,
	input  logic                  mode,
	input  logic [DIM_BITS-1:0]   first_row,
	input  logic [INDEX_BITS-1:0] split,
	input  logic [INDEX_BITS-1:0] total,
	output tic_ctl_t              ctl_o,
	output logic [RAD_W-1:0]      rad_o,
	output logic [INDEX_BITS-1:0] dvd_o
);

	localparam int BW = DIM_BITS + 1;

	logic [BW-1:0]         base;
	logic [2*BW-1:0]       sq_full;
	logic [RAD_W-1:0]      sq_q;
	logic [INDEX_BITS-1:0] idx_s1;
	tic_ctl_t              ctl_s1;
	logic [INDEX_BITS-1:0] x;
	logic [INDEX_BITS-1:0] dvd;
	logic [RAD_W-1:0]      x8;
	logic [RAD_W-1:0]      idx8;
	logic [RAD_W-1:0]      rad;

	// Square of the trapezoid's leading term, held from the configuration.
	always_comb begin
		if (mode == MODE_LOWER) begin
			base = (first_row == '0) ? BW'(1) : ({first_row, 1'b0} - BW'(1));
		end else begin
			base = {first_row, 1'b1};
		end
		sq_full = base * base;
	end

	always_ff @(posedge clk) begin
		sq_q <= RAD_W'(sq_full);
	end

	// Stage one: register the index and classify it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid <= in_valid;
			ctl_s1.inr   <= (linear_index < total);
			ctl_s1.top   <= (linear_index < split);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1 <= linear_index;
		end
	end

	// Radicand and dividend of the item.
	always_comb begin
		x    = idx_s1 - split;
		dvd  = ctl_s1.top ? idx_s1 : x;
		x8   = RAD_W'(x) << 3;
		idx8 = RAD_W'(idx_s1) << 3;
		if (mode == MODE_UPPER) begin
			rad = (x8 > sq_q) ? '0 : (sq_q - x8);
		end else begin
			rad = sq_q + idx8;
		end
	end

	// Stage two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_o <= rad;
			dvd_o <= dvd;
		end
	end

endmodule

// File: design/tic_core.sv
`timescale 1ns / 1ps
module tic_core import tic_pkg::*; #(
	parameter int DIM_BITS   = DIM_BITS_DEF,
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic [DIM_BITS-1:0]   cols,
	input  logic [INDEX_BITS-1:0] split,
	input  tic_ctl_t              ctl_i,
	input  logic [RAD_W-1:0]      rad_i,
	input  logic [INDEX_BITS-1:0] dvd_i,
	output tic_ctl_t              ctl_o,
	output logic [ROOT_W-1:0]     root_o,
	output logic                  exact_o,
	output logic [INDEX_BITS-1:0] qa_o,
	output logic [DIM_BITS-1:0]   ra_o,
	output logic [INDEX_BITS-1:0] qb_o,
	output logic [DIM_BITS+1:0]   lo_o
);

	localparam int DEPTH = max_int(INDEX_BITS, SQRT_STEPS);
	localparam int W2    = DIM_BITS + 2;

	tic_ctl_t              ctl_s  [DEPTH];
	logic [SREM_W-1:0]     srem_s [DEPTH];
	logic [ROOT_W-1:0]     root_s [DEPTH];
	logic [RAD_W-1:0]      rad_s  [DEPTH];
	logic [DIM_BITS-1:0]   ra_s   [DEPTH];
	logic [INDEX_BITS-1:0] qa_s   [DEPTH];
	logic [DIM_BITS-1:0]   rb_s   [DEPTH];
	logic [INDEX_BITS-1:0] qb_s   [DEPTH];
	logic [W2-1:0]         lo_s   [DEPTH];

	// One root digit and one quotient bit per stage for each lane, until that lane's steps run out.
	for (genvar k = 0; k < DEPTH; k++) begin : g_st
		tic_ctl_t              p_ctl;
		logic [SREM_W-1:0]     p_srem;
		logic [ROOT_W-1:0]     p_root;
		logic [RAD_W-1:0]      p_rad;
		logic [DIM_BITS-1:0]   p_ra;
		logic [INDEX_BITS-1:0] p_qa;
		logic [DIM_BITS-1:0]   p_rb;
		logic [INDEX_BITS-1:0] p_qb;
		logic [W2-1:0]         p_lo;
		logic [SREM_W-1:0]     n_srem;
		logic [ROOT_W-1:0]     n_root;
		logic [RAD_W-1:0]      n_rad;
		logic [DIM_BITS-1:0]   n_ra;
		logic [INDEX_BITS-1:0] n_qa;
		logic [DIM_BITS-1:0]   n_rb;
		logic [INDEX_BITS-1:0] n_qb;
		logic [SREM_W-1:0]     s_try;
		logic [SREM_W-1:0]     s_sub;
		logic [DIM_BITS:0]     ta;
		logic [DIM_BITS:0]     tb;

		if (k == 0) begin : g_head
			assign p_ctl  = ctl_i;
			assign p_srem = '0;
			assign p_root = '0;
			assign p_rad  = rad_i;
			assign p_ra   = '0;
			assign p_qa   = dvd_i;
			assign p_rb   = '0;
			assign p_qb   = split;
			assign p_lo   = W2'(dvd_i);
		end else begin : g_link
			assign p_ctl  = ctl_s[k-1];
			assign p_srem = srem_s[k-1];
			assign p_root = root_s[k-1];
			assign p_rad  = rad_s[k-1];
			assign p_ra   = ra_s[k-1];
			assign p_qa   = qa_s[k-1];
			assign p_rb   = rb_s[k-1];
			assign p_qb   = qb_s[k-1];
			assign p_lo   = lo_s[k-1];
		end

		// Restoring square root step.
		always_comb begin
			s_try  = {p_srem[SREM_W-3:0], p_rad[RAD_W-1 -: 2]};
			s_sub  = {1'b0, p_root, 2'b01};
			n_srem = p_srem;
			n_root = p_root;
			n_rad  = p_rad;
			if (k < SQRT_STEPS) begin
				n_rad = p_rad << 2;
				if (s_try >= s_sub) begin
					n_srem = s_try - s_sub;
					n_root = {p_root[ROOT_W-2:0], 1'b1};
				end else begin
					n_srem = s_try;
					n_root = {p_root[ROOT_W-2:0], 1'b0};
				end
			end
		end

		// Restoring division steps for the item and for the split size.
		always_comb begin
			ta   = {p_ra, p_qa[INDEX_BITS-1]};
			tb   = {p_rb, p_qb[INDEX_BITS-1]};
			n_ra = p_ra;
			n_qa = p_qa;
			n_rb = p_rb;
			n_qb = p_qb;
			if (k < INDEX_BITS) begin
				if (ta >= {1'b0, cols}) begin
					n_ra = DIM_BITS'(ta - {1'b0, cols});
					n_qa = {p_qa[INDEX_BITS-2:0], 1'b1};
				end else begin
					n_ra = ta[DIM_BITS-1:0];
					n_qa = {p_qa[INDEX_BITS-2:0], 1'b0};
				end
				if (tb >= {1'b0, cols}) begin
					n_rb = DIM_BITS'(tb - {1'b0, cols});
					n_qb = {p_qb[INDEX_BITS-2:0], 1'b1};
				end else begin
					n_rb = tb[DIM_BITS-1:0];
					n_qb = {p_qb[INDEX_BITS-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else if (en) begin
				ctl_s[k] <= p_ctl;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				srem_s[k] <= n_srem;
				root_s[k] <= n_root;
				rad_s[k]  <= n_rad;
				ra_s[k]   <= n_ra;
				qa_s[k]   <= n_qa;
				rb_s[k]   <= n_rb;
				qb_s[k]   <= n_qb;
				lo_s[k]   <= p_lo;
			end
		end
	end

	assign ctl_o   = ctl_s[DEPTH-1];
	assign root_o  = root_s[DEPTH-1];
	assign exact_o = (srem_s[DEPTH-1] == '0);
	assign qa_o    = qa_s[DEPTH-1];
	assign ra_o    = ra_s[DEPTH-1];
	assign qb_o    = qb_s[DEPTH-1];
	assign lo_o    = lo_s[DEPTH-1];

endmodule

// File: design/tic_back.sv
`timescale 1ns / 1ps
module tic_back import tic_pkg::*; #(
	parameter int DIM_BITS   = DIM_BITS_DEF,
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	output logic                  en,
	input  logic                  mode,
	input  logic [DIM_BITS-1:0]   first_row,
	input  logic [DIM_BITS-1:0]   cols,
	input  logic [DIM_BITS-1:0]   offset,
	input  tic_ctl_t              ctl_i,
	input  logic [ROOT_W-1:0]     root_i,
	input  logic                  exact_i,
	input  logic [INDEX_BITS-1:0] qa_i,
	input  logic [DIM_BITS-1:0]   ra_i,
	input  logic [INDEX_BITS-1:0] qb_i,
	input  logic [DIM_BITS+1:0]   lo_i,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [DIM_BITS:0]     row_index,
	output logic [DIM_BITS:0]     col_index,
	output logic                  valid_res
);

	localparam int O  = DIM_BITS + 1;
	localparam int W2 = DIM_BITS + 2;
	localparam int W3 = DIM_BITS + 3;

	logic [RAD_W-1:0] root64;
	logic [W3-1:0]    sv;
	logic [W3-1:0]    diff;
	logic [W2-1:0]    rt;
	logic [W2-1:0]    f2;
	logic [W2-1:0]    kf;
	logic [2*W2-1:0]  prod;

	tic_ctl_t            ctl_s1;
	logic [W2-1:0]       rt_s1;
	logic [DIM_BITS-1:0] ra_s1;
	logic [O-1:0]        qb_s1;
	logic [W2-1:0]       lo_s1;
	tic_ctl_t            ctl_s2;
	logic [W2-1:0]       rt_s2;
	logic [W2-1:0]       p_s2;
	logic [DIM_BITS-1:0] ra_s2;
	logic [O-1:0]        qb_s2;
	logic [W2-1:0]       lo_s2;

	logic [O-1:0] r_fin;
	logic [O-1:0] c_fin;
	logic         last_v;
	logic         skid_valid_q;
	logic [O-1:0] skid_row_q;
	logic [O-1:0] skid_col_q;
	logic         skid_res_q;

	// The pipeline moves whenever the skid stage is free.
	assign en     = !skid_valid_q;
	assign f2     = W2'({first_row, 1'b0});
	assign root64 = RAD_W'(root_i);
	assign sv     = root64[W3-1:0];

	// Row within the trapezoid, or the rectangle row.
	always_comb begin
		diff = '0;
		if (mode == MODE_UPPER) begin
			diff = W3'({first_row, 1'b1}) - sv - (exact_i ? W3'(0) : W3'(1));
		end else begin
			diff = sv + W3'(1) - W3'({first_row, 1'b0});
		end
		if (ctl_i.top) begin
			if (mode == MODE_UPPER) begin
				rt = W2'(qa_i);
			end else begin
				rt = diff[W3-1:1];
			end
		end else if (mode == MODE_UPPER) begin
			rt = diff[W3-1:1];
		end else begin
			rt = W2'(qa_i) + W2'(cols) - W2'(first_row) + W2'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_s1 <= rt;
			ra_s1 <= ra_i;
			qb_s1 <= O'(qb_i);
			lo_s1 <= lo_i;
		end
	end

	// Elements before this trapezoid row: one narrow product.
	always_comb begin
		if (mode == MODE_UPPER) begin
			kf = f2 - rt_s1 + W2'(1);
		end else begin
			kf = f2 + rt_s1 - W2'(1);
		end
		prod = kf * rt_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_s2 <= rt_s1;
			p_s2  <= prod[W2-1:0];
			ra_s2 <= ra_s1;
			qb_s2 <= qb_s1;
			lo_s2 <= lo_s1;
		end
	end

	// Final row and column.
	always_comb begin
		r_fin = '0;
		c_fin = '0;
		if (mode == MODE_UPPER) begin
			if (ctl_s2.top) begin
				r_fin = O'(rt_s2);
				c_fin = O'(ra_s2) + O'(offset);
			end else begin
				r_fin = O'(rt_s2) + qb_s2;
				c_fin = lo_s2[O-1:0] - p_s2[W2-1:1] + O'(rt_s2) + O'(offset);
			end
		end else begin
			r_fin = O'(rt_s2) + O'(offset);
			if (ctl_s2.top) begin
				c_fin = lo_s2[O-1:0] - p_s2[W2-1:1];
			end else begin
				c_fin = O'(ra_s2);
			end
		end
		if (!ctl_s2.inr) begin
			r_fin = '0;
			c_fin = '0;
		end
	end

	assign last_v = ctl_s2.valid && en;

	// Output register with a skid stage behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid || out_ready) begin
			if (skid_valid_q) begin
				out_valid    <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid <= last_v;
			end
		end else if (last_v) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid || out_ready) begin
			if (skid_valid_q) begin
				row_index <= skid_row_q;
				col_index <= skid_col_q;
				valid_res <= skid_res_q;
			end else begin
				row_index <= r_fin;
				col_index <= c_fin;
				valid_res <= ctl_s2.inr;
			end
		end else if (last_v) begin
			skid_row_q <= r_fin;
			skid_col_q <= c_fin;
			skid_res_q <= ctl_s2.inr;
		end
	end

	// An out-of-range beat carries zero coordinates.
	a_zero_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> row_index == '0 && col_index == '0)
		else $error("out-of-range beat with non-zero coordinates");

	// The skid stage only fills behind a held output beat.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid)
		else $error("skid stage full without an output beat");

	// A full skid stage stays full while the receiver stalls.
	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !out_ready |=> skid_valid_q)
		else $error("skid beat lost during stall");

	// A full skid stage empties once the output beat is taken.
	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && out_ready |=> !skid_valid_q && out_valid)
		else $error("skid stage failed to drain");

endmodule

// File: design/triangle_index_to_coordinate_core.sv
`timescale 1ns / 1ps
// Triangle index to coordinate.
// Input channel in_valid/in_ready carries linear_index; output channel
// out_valid/out_ready carries row_index, col_index and valid_res (low when the
// index is at or beyond total_size, with zero coordinates). The configuration
// channel cfg_valid/cfg_ready writes register cfg_index with cfg_data:
// 0 mode, 1 num_cols, 2 first_row_count, 3 split_size, 4 total_size,
// 5 index_offset; other indexes are ignored. cfg_ready is always high; write
// only while no beat is in flight.
// Throughput is one beat per cycle while the output is not stalled. The
// square root and divider stages give one root digit and one quotient bit
// per stage.
// Reset clears all valid bits and returns the registers to mode upper,
// num_cols 1 and zero elsewhere; no clearing pass is needed.
// When the receiver stalls, one more beat is held in a skid stage behind the
// output register and input keeps flowing until it fills; in_ready then drops
// and the pipeline holds with nothing lost or repeated.
module triangle_index_to_coordinate_core import tic_pkg::*; #(
	parameter int DIM_BITS   = DIM_BITS_DEF,
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	output logic                                       in_ready,
	input  logic [INDEX_BITS-1:0]                      linear_index,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic [DIM_BITS:0]                          row_index,
	output logic [DIM_BITS:0]                          col_index,
	output logic                                       valid_res,
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]                       cfg_index,
	input  logic [max_int(INDEX_BITS, DIM_BITS)-1:0]   cfg_data
);

	logic                  mode_q;
	logic [DIM_BITS-1:0]   num_cols_q;
	logic [DIM_BITS-1:0]   first_row_q;
	logic [INDEX_BITS-1:0] split_q;
	logic [INDEX_BITS-1:0] total_q;
	logic [DIM_BITS-1:0]   offset_q;
	logic [DIM_BITS-1:0]   cols;
	logic                  en;

	tic_ctl_t              f_ctl;
	logic [RAD_W-1:0]      f_rad;
	logic [INDEX_BITS-1:0] f_dvd;
	tic_ctl_t              c_ctl;
	logic [ROOT_W-1:0]     c_root;
	logic                  c_exact;
	logic [INDEX_BITS-1:0] c_qa;
	logic [DIM_BITS-1:0]   c_ra;
	logic [INDEX_BITS-1:0] c_qb;
	logic [DIM_BITS+1:0]   c_lo;

	assign cfg_ready = 1'b1;
	assign in_ready  = en;
	assign cols      = (num_cols_q == '0) ? DIM_BITS'(1) : num_cols_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_UPPER;
			num_cols_q  <= DIM_BITS'(1);
			first_row_q <= '0;
			split_q     <= '0;
			total_q     <= '0;
			offset_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:      mode_q      <= cfg_data[0];
				REG_NUM_COLS:  num_cols_q  <= cfg_data[DIM_BITS-1:0];
				REG_FIRST_ROW: first_row_q <= cfg_data[DIM_BITS-1:0];
				REG_SPLIT:     split_q     <= cfg_data[INDEX_BITS-1:0];
				REG_TOTAL:     total_q     <= cfg_data[INDEX_BITS-1:0];
				REG_OFFSET:    offset_q    <= cfg_data[DIM_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	tic_front #(
		.DIM_BITS   (DIM_BITS),
		.INDEX_BITS (INDEX_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (in_valid),
		.linear_index (linear_index),
		.mode         (mode_q),
		.first_row    (first_row_q),
		.split        (split_q),
		.total        (total_q),
		.ctl_o        (f_ctl),
		.rad_o        (f_rad),
		.dvd_o        (f_dvd)
	);

	tic_core #(
		.DIM_BITS   (DIM_BITS),
		.INDEX_BITS (INDEX_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.cols    (cols),
		.split   (split_q),
		.ctl_i   (f_ctl),
		.rad_i   (f_rad),
		.dvd_i   (f_dvd),
		.ctl_o   (c_ctl),
		.root_o  (c_root),
		.exact_o (c_exact),
		.qa_o    (c_qa),
		.ra_o    (c_ra),
		.qb_o    (c_qb),
		.lo_o    (c_lo)
	);

	tic_back #(
		.DIM_BITS   (DIM_BITS),
		.INDEX_BITS (INDEX_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.mode      (mode_q),
		.first_row (first_row_q),
		.cols      (cols),
		.offset    (offset_q),
		.ctl_i     (c_ctl),
		.root_i    (c_root),
		.exact_i   (c_exact),
		.qa_i      (c_qa),
		.ra_i      (c_ra),
		.qb_i      (c_qb),
		.lo_i      (c_lo),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.row_index (row_index),
		.col_index (col_index),
		.valid_res (valid_res)
	);

endmodule
